// File: rtl/core/dmxdim_pkg.sv
// Shared types, constants and the gamma table of the DMX dimmer and fan controller.
`default_nettype none

package dmxdim_pkg;

   // Default sizing of the frame and of the idle timeout.
   localparam int FRAME_BYTES_DEFAULT   = 514;
   localparam int TIMEOUT_TICKS_DEFAULT = 500;

   // Fixed widths of the state and of the ports.
   localparam int POSITION_WIDTH    = 10;
   localparam int IDLE_WIDTH        = 10;
   localparam int CHANNEL_COUNT     = 3;
   localparam int UNIVERSE_CHANNELS = 512;
   localparam int QUEUE_DEPTH       = 4;
   localparam int CSR_INDEX_WIDTH   = 3;
   localparam int CSR_DATA_WIDTH    = 16;

   // Input item kinds.
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_BYTE  = 2'd0;
   localparam kind_type KIND_BREAK = 2'd1;
   localparam kind_type KIND_TICK  = 2'd2;

   // Result event codes.
   typedef logic event_type;
   localparam event_type EVENT_FRAME   = 1'b0;
   localparam event_type EVENT_TIMEOUT = 1'b1;

   // Configuration register indexes.
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   localparam csr_index_type REG_START_ADDRESS     = 3'd0;
   localparam csr_index_type REG_DUTY_SCALE_FIRST  = 3'd1;
   localparam csr_index_type REG_DUTY_SCALE_SECOND = 3'd2;
   localparam csr_index_type REG_DUTY_SCALE_THIRD  = 3'd3;
   localparam csr_index_type REG_SMOOTHING_WEIGHT  = 3'd4;
   localparam csr_index_type REG_FAN_OFFSET        = 3'd5;
   localparam csr_index_type REG_FAN_OFF_BELOW     = 3'd6;
   localparam csr_index_type REG_FAN_CEILING       = 3'd7;

   // Configuration register reset values.
   localparam logic [8:0]  START_ADDRESS_RESET     = 9'd0;
   localparam logic [15:0] DUTY_SCALE_FIRST_RESET  = 16'd16384;
   localparam logic [15:0] DUTY_SCALE_SECOND_RESET = 16'd32768;
   localparam logic [15:0] DUTY_SCALE_THIRD_RESET  = 16'd29491;
   localparam logic [15:0] SMOOTHING_WEIGHT_RESET  = 16'd66;
   localparam logic [12:0] FAN_OFFSET_RESET        = 13'd2000;
   localparam logic [12:0] FAN_OFF_BELOW_RESET     = 13'd2500;
   localparam logic [12:0] FAN_CEILING_RESET       = 13'd4096;

   // Reciprocal of three for a 14-bit dividend: (x * 43691) >> 17 is exact.
   localparam logic [15:0] RECIP_THREE = 16'd43691;

   typedef logic [7:0] level_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [8:0]             start_address;
      logic [2:0][15:0]       duty_scale;
      logic [15:0]            smoothing_weight;
      logic [12:0]            fan_offset;
      logic [12:0]            fan_off_below;
      logic [12:0]            fan_ceiling;
   } cfg_type;

   // Command handed from the front to the back through the queue.
   typedef struct packed {
      logic                   timeout;
      logic [2:0][7:0]        levels;
   } cmd_type;

   // Gamma correction table, 8-bit level to 16-bit drive.
   localparam logic [15:0] GAMMA_ROM [256] = '{
      16'd0, 16'd1, 16'd1, 16'd1, 16'd2, 16'd2, 16'd3, 16'd4,
      16'd5, 16'd7, 16'd9, 16'd11, 16'd14, 16'd17, 16'd20, 16'd25,
      16'd29, 16'd34, 16'd40, 16'd47, 16'd54, 16'd61, 16'd70, 16'd79,
      16'd89, 16'd99, 16'd111, 16'd123, 16'd136, 16'd150, 16'd165, 16'd180,
      16'd197, 16'd215, 16'd233, 16'd253, 16'd274, 16'd296, 16'd318, 16'd342,
      16'd367, 16'd394, 16'd421, 16'd450, 16'd479, 16'd511, 16'd543, 16'd576,
      16'd611, 16'd648, 16'd685, 16'd724, 16'd765, 16'd807, 16'd850, 16'd895,
      16'd941, 16'd989, 16'd1038, 16'd1089, 16'd1141, 16'd1195, 16'd1251, 16'd1308,
      16'd1367, 16'd1428, 16'd1490, 16'd1554, 16'd1620, 16'd1687, 16'd1757, 16'd1828,
      16'd1901, 16'd1976, 16'd2052, 16'd2131, 16'd2211, 16'd2294, 16'd2378, 16'd2464,
      16'd2553, 16'd2643, 16'd2735, 16'd2830, 16'd2926, 16'd3025, 16'd3125, 16'd3228,
      16'd3333, 16'd3440, 16'd3549, 16'd3661, 16'd3775, 16'd3891, 16'd4009, 16'd4129,
      16'd4252, 16'd4377, 16'd4505, 16'd4635, 16'd4767, 16'd4902, 16'd5039, 16'd5178,
      16'd5320, 16'd5465, 16'd5612, 16'd5761, 16'd5913, 16'd6068, 16'd6225, 16'd6384,
      16'd6547, 16'd6712, 16'd6879, 16'd7050, 16'd7223, 16'd7398, 16'd7577, 16'd7758,
      16'd7942, 16'd8128, 16'd8318, 16'd8510, 16'd8705, 16'd8903, 16'd9104, 16'd9308,
      16'd9515, 16'd9724, 16'd9937, 16'd10152, 16'd10371, 16'd10592, 16'd10817, 16'd11044,
      16'd11275, 16'd11508, 16'd11745, 16'd11985, 16'd12228, 16'd12474, 16'd12723, 16'd12976,
      16'd13231, 16'd13490, 16'd13752, 16'd14018, 16'd14286, 16'd14558, 16'd14833, 16'd15112,
      16'd15394, 16'd15679, 16'd15968, 16'd16260, 16'd16555, 16'd16854, 16'd17156, 16'd17462,
      16'd17771, 16'd18084, 16'd18400, 16'd18720, 16'd19043, 16'd19370, 16'd19701, 16'd20035,
      16'd20372, 16'd20714, 16'd21059, 16'd21407, 16'd21760, 16'd22116, 16'd22476, 16'd22839,
      16'd23206, 16'd23577, 16'd23952, 16'd24331, 16'd24714, 16'd25100, 16'd25490, 16'd25884,
      16'd26282, 16'd26684, 16'd27090, 16'd27500, 16'd27913, 16'd28331, 16'd28753, 16'd29178,
      16'd29608, 16'd30042, 16'd30480, 16'd30922, 16'd31368, 16'd31818, 16'd32272, 16'd32731,
      16'd33193, 16'd33660, 16'd34131, 16'd34606, 16'd35086, 16'd35569, 16'd36057, 16'd36550,
      16'd37046, 16'd37547, 16'd38052, 16'd38562, 16'd39076, 16'd39594, 16'd40117, 16'd40644,
      16'd41175, 16'd41711, 16'd42252, 16'd42796, 16'd43346, 16'd43900, 16'd44458, 16'd45021,
      16'd45589, 16'd46161, 16'd46738, 16'd47319, 16'd47905, 16'd48496, 16'd49091, 16'd49691,
      16'd50296, 16'd50905, 16'd51519, 16'd52138, 16'd52761, 16'd53390, 16'd54023, 16'd54661,
      16'd55304, 16'd55951, 16'd56604, 16'd57261, 16'd57923, 16'd58590, 16'd59262, 16'd59939,
      16'd60621, 16'd61308, 16'd62000, 16'd62697, 16'd63399, 16'd64106, 16'd64818, 16'd65535
   };

endpackage

`default_nettype wire

// File: rtl/core/dmxdim_if.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface dmxdim_req_if;
   logic                 valid;
   logic                 ready;
   dmxdim_pkg::kind_type kind;
   logic [7:0]           data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface dmxdim_rsp_if;
   logic        valid;
   logic        ready;
   logic        event_res;
   logic [15:0] first_duty;
   logic [15:0] second_duty;
   logic [15:0] third_duty;
   logic [12:0] fan_compare;

   modport source (output valid, output event_res, output first_duty, output second_duty,
                   output third_duty, output fan_compare, input ready);
   modport sink   (input valid, input event_res, input first_duty, input second_duty,
                   input third_duty, input fan_compare, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dmx_rgb_dimmer_fan_control.sv
// Top level of the DMX512 RGB dimmer and fan controller.
//
//   Channel  Direction  Handshake          Carries
//   req_bus  in         valid/ready        kind, data_byte
//   rsp_bus  out        valid/ready        event_res, three duties, fan_compare
//   csr_*    in         write enable only  register index and write data
//
// One input item is accepted per cycle while the command queue has room.
// A break or an expiring tick has its result valid once its command has passed the queue:
// the queue entry is written at the accepting edge and four pipeline stages follow
// (gamma, duty and average, fan smoothing, limiting and result register).
// Reset is synchronous; it clears the frame state, the fan level and the queue,
// and loads the register defaults. A stalled result holds the whole back end,
// and the front keeps accepting bytes and ticks until the queue fills.
`default_nettype none

module dmx_rgb_dimmer_fan_control #(
   parameter int FRAME_BYTES   = dmxdim_pkg::FRAME_BYTES_DEFAULT,
   parameter int TIMEOUT_TICKS = dmxdim_pkg::TIMEOUT_TICKS_DEFAULT
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   dmxdim_req_if.sink                                      req_bus,
   dmxdim_rsp_if.source                                    rsp_bus,
   input  wire logic                                       csr_write_enable,
   input  wire dmxdim_pkg::csr_index_type                  csr_index,
   input  wire logic [dmxdim_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data
);
   import dmxdim_pkg::*;

   cfg_type cfg_ff;
   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    queue_empty;
   logic    pop;
   cmd_type head_cmd;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_address    <= START_ADDRESS_RESET;
         cfg_ff.duty_scale[0]    <= DUTY_SCALE_FIRST_RESET;
         cfg_ff.duty_scale[1]    <= DUTY_SCALE_SECOND_RESET;
         cfg_ff.duty_scale[2]    <= DUTY_SCALE_THIRD_RESET;
         cfg_ff.smoothing_weight <= SMOOTHING_WEIGHT_RESET;
         cfg_ff.fan_offset       <= FAN_OFFSET_RESET;
         cfg_ff.fan_off_below    <= FAN_OFF_BELOW_RESET;
         cfg_ff.fan_ceiling      <= FAN_CEILING_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_START_ADDRESS:     cfg_ff.start_address    <= csr_write_data[8:0];
            REG_DUTY_SCALE_FIRST:  cfg_ff.duty_scale[0]    <= csr_write_data;
            REG_DUTY_SCALE_SECOND: cfg_ff.duty_scale[1]    <= csr_write_data;
            REG_DUTY_SCALE_THIRD:  cfg_ff.duty_scale[2]    <= csr_write_data;
            REG_SMOOTHING_WEIGHT:  cfg_ff.smoothing_weight <= csr_write_data;
            REG_FAN_OFFSET:        cfg_ff.fan_offset       <= csr_write_data[12:0];
            REG_FAN_OFF_BELOW:     cfg_ff.fan_off_below    <= csr_write_data[12:0];
            REG_FAN_CEILING:       cfg_ff.fan_ceiling      <= csr_write_data[12:0];
            default: begin
               cfg_ff.fan_ceiling <= cfg_ff.fan_ceiling;
            end
         endcase
      end
   end

   // Front end: frame capture and command issue.
   dmxdim_front #(
      .FRAME_BYTES   (FRAME_BYTES),
      .TIMEOUT_TICKS (TIMEOUT_TICKS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .start_address (cfg_ff.start_address),
      .push          (push),
      .push_cmd      (push_cmd),
      .queue_full    (queue_full)
   );

   // Command queue.
   dmxdim_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head_cmd (head_cmd)
   );

   // Back end: drive computation and result register.
   dmxdim_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_bus     (rsp_bus)
   );

endmodule

`default_nettype wire

// File: rtl/core/dmxdim_queue.sv
// Short command queue between the frame front end and the drive back end.
`default_nettype none

module dmxdim_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire dmxdim_pkg::cmd_type push_cmd,
   output logic                     full,
   input  wire logic                pop,
   output logic                     empty,
   output dmxdim_pkg::cmd_type      head_cmd
);
   import dmxdim_pkg::*;

   localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == COUNT_WIDTH'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // The fill count never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue fill count exceeds depth");

   // A push with no pop grows the count by one.
   a_count_push: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// File: rtl/core/dmxdim_front.sv
// Front end: takes bytes, breaks and ticks, captures channels and issues frame and timeout commands.
`default_nettype none

module dmxdim_front #(
   parameter int FRAME_BYTES   = dmxdim_pkg::FRAME_BYTES_DEFAULT,
   parameter int TIMEOUT_TICKS = dmxdim_pkg::TIMEOUT_TICKS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   dmxdim_req_if.sink               req_bus,
   input  wire logic [8:0]          start_address,
   output logic                     push,
   output dmxdim_pkg::cmd_type      push_cmd,
   input  wire logic                queue_full
);
   import dmxdim_pkg::*;

   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [IDLE_WIDTH-1:0]     idle_ff, idle_in;
   level_type                 level_ff [CHANNEL_COUNT];
   level_type                 level_in [CHANNEL_COUNT];
   logic                      accept;
   logic                      in_frame;
   logic [POSITION_WIDTH-1:0] channel;
   logic [POSITION_WIDTH-1:0] offset;
   logic                      captured;
   logic                      timed_out;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;

   // Byte position decode for channel capture.
   assign in_frame  = ({1'b0, pos_ff} < (POSITION_WIDTH + 1)'(FRAME_BYTES));
   assign channel   = pos_ff - 1'b1;
   assign offset    = channel - {1'b0, start_address};
   assign captured  = in_frame && (pos_ff != '0) && (channel >= {1'b0, start_address})
                      && (offset < POSITION_WIDTH'(CHANNEL_COUNT));
   assign timed_out = (idle_ff >= IDLE_WIDTH'(TIMEOUT_TICKS));

   // Next state and command for each kind of item.
   always_comb begin
      pos_in   = pos_ff;
      idle_in  = idle_ff;
      level_in = level_ff;
      push     = 1'b0;
      push_cmd.timeout = 1'b0;
      for (int k = 0; k < CHANNEL_COUNT; k++) begin
         // Channels beyond the universe drive as level zero.
         push_cmd.levels[k] = (({1'b0, start_address} + POSITION_WIDTH'(k))
                               < POSITION_WIDTH'(UNIVERSE_CHANNELS)) ? level_ff[k] : '0;
      end
      if (accept) begin
         case (req_bus.kind)
            KIND_BYTE: begin
               if (captured) begin
                  level_in[offset[1:0]] = req_bus.data_byte;
               end
               if (in_frame && (pos_ff != '1)) begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            KIND_BREAK: begin
               push    = 1'b1;
               pos_in  = '0;
               idle_in = '0;
            end
            KIND_TICK: begin
               if (timed_out) begin
                  push             = 1'b1;
                  push_cmd.timeout = 1'b1;
                  pos_in           = '0;
                  idle_in          = '0;
                  for (int k = 0; k < CHANNEL_COUNT; k++) begin
                     level_in[k] = '0;
                  end
               end else begin
                  idle_in = idle_ff + 1'b1;
               end
            end
            default: begin
               pos_in = pos_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         idle_ff <= '0;
         for (int k = 0; k < CHANNEL_COUNT; k++) begin
            level_ff[k] <= '0;
         end
      end else begin
         pos_ff   <= pos_in;
         idle_ff  <= idle_in;
         level_ff <= level_in;
      end
   end

   // A break restarts both the byte position and the idle count.
   a_break_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_bus.kind == KIND_BREAK)) |=> ((pos_ff == '0) && (idle_ff == '0)))
      else $error("break did not clear frame position");

   // Only breaks and expiring ticks issue a command.
   a_push_source: assert property (@(posedge clock) disable iff (reset)
      push |-> (accept && ((req_bus.kind == KIND_BREAK) ||
                           ((req_bus.kind == KIND_TICK) && timed_out))))
      else $error("command issued without a break or timeout");

endmodule

`default_nettype wire

// File: rtl/core/dmxdim_back.sv
// Back end: gamma lookup, duty scaling, fan smoothing and limiting, result register.
`default_nettype none

module dmxdim_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dmxdim_pkg::cfg_type cfg,
   input  wire logic                queue_empty,
   input  wire dmxdim_pkg::cmd_type head_cmd,
   output logic                     pop,
   dmxdim_rsp_if.source             rsp_bus
);
   import dmxdim_pkg::*;

   // Global advance: the pipeline moves unless a held result is not taken.
   logic advance;

   // Stage A: gamma values.
   logic             a_valid_ff;
   logic             a_timeout_ff;
   logic [2:0][15:0] a_gamma_ff;

   // Stage B: scaled duties and the channel average.
   logic             b_valid_ff;
   logic             b_timeout_ff;
   logic [2:0][15:0] b_duty_ff;
   logic [11:0]      b_avg_ff;
   logic [17:0]      gamma_sum;
   logic [30:0]      avg_product;
   logic [2:0][31:0] duty_product;

   // Stage C: fan level update.
   logic               c_valid_ff;
   logic               c_timeout_ff;
   logic [2:0][15:0]   c_duty_ff;
   logic [15:0]        fan_level_ff, fan_level_in;
   logic signed [17:0] fan_diff;
   logic signed [34:0] fan_step;
   logic [18:0]        fan_mix;

   // Stage D: result register.
   logic        d_valid_ff;
   logic        d_event_ff;
   logic [2:0][15:0] d_duty_ff;
   logic [12:0] d_compare_ff, d_compare_in;
   logic [16:0] fan_sum;

   assign advance = !(d_valid_ff && !rsp_bus.ready);
   assign pop     = advance && !queue_empty;

   // Stage B arithmetic: duty products and sum / 48 as (sum >> 4) / 3.
   assign gamma_sum   = {2'b00, a_gamma_ff[0]} + {2'b00, a_gamma_ff[1]}
                        + {2'b00, a_gamma_ff[2]};
   assign avg_product = 31'(gamma_sum[17:4]) * 31'(RECIP_THREE);
   always_comb begin
      for (int k = 0; k < CHANNEL_COUNT; k++) begin
         duty_product[k] = 32'(a_gamma_ff[k]) * 32'(cfg.duty_scale[k]);
      end
   end

   // Stage C arithmetic: level + floor(w * (avg - level) / 65536).
   assign fan_diff = $signed({6'b000000, b_avg_ff}) - $signed({2'b00, fan_level_ff});
   assign fan_step = 35'($signed({1'b0, cfg.smoothing_weight})) * 35'(fan_diff);
   assign fan_mix  = {3'b000, fan_level_ff} + fan_step[34:16];
   assign fan_level_in = b_timeout_ff ? '0 : fan_mix[15:0];

   // Stage D: offset, cut-off first, then ceiling.
   assign fan_sum = {1'b0, fan_level_ff} + {4'b0000, cfg.fan_offset};
   always_comb begin
      if (fan_sum < {4'b0000, cfg.fan_off_below}) begin
         d_compare_in = '0;
      end else if (fan_sum > {4'b0000, cfg.fan_ceiling}) begin
         d_compare_in = cfg.fan_ceiling;
      end else begin
         d_compare_in = fan_sum[12:0];
      end
   end

   // Valid bits of all stages and the fan level.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         fan_level_ff <= '0;
      end else if (advance) begin
         a_valid_ff <= pop;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         if (b_valid_ff) begin
            fan_level_ff <= fan_level_in;
         end
      end
   end

   // Payload of all stages.
   always_ff @(posedge clock) begin
      if (advance) begin
         a_timeout_ff <= head_cmd.timeout;
         for (int k = 0; k < CHANNEL_COUNT; k++) begin
            a_gamma_ff[k] <= GAMMA_ROM[head_cmd.levels[k]];
            b_duty_ff[k]  <= duty_product[k][31:16];
         end
         b_timeout_ff <= a_timeout_ff;
         b_avg_ff     <= avg_product[28:17];
         c_timeout_ff <= b_timeout_ff;
         c_duty_ff    <= b_duty_ff;
         d_event_ff   <= c_timeout_ff ? EVENT_TIMEOUT : EVENT_FRAME;
         d_duty_ff    <= c_timeout_ff ? '0 : c_duty_ff;
         d_compare_ff <= c_timeout_ff ? '0 : d_compare_in;
      end
   end

   assign rsp_bus.valid       = d_valid_ff;
   assign rsp_bus.event_res   = d_event_ff;
   assign rsp_bus.first_duty  = d_duty_ff[0];
   assign rsp_bus.second_duty = d_duty_ff[1];
   assign rsp_bus.third_duty  = d_duty_ff[2];
   assign rsp_bus.fan_compare = d_compare_ff;

   // A timeout result carries all-zero drive values.
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.event_res == EVENT_TIMEOUT)) |->
      ((rsp_bus.first_duty == '0) && (rsp_bus.second_duty == '0) &&
       (rsp_bus.third_duty == '0) && (rsp_bus.fan_compare == '0)))
      else $error("timeout result with nonzero drive values");

   // A timeout leaves the fan level cleared.
   a_timeout_fan: assert property (@(posedge clock) disable iff (reset)
      (advance && b_valid_ff && b_timeout_ff) |=> (fan_level_ff == '0))
      else $error("fan level not cleared on timeout");

endmodule

`default_nettype wire
